FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CDPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define CDPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: hdl/cdpa_pkg.sv
// Package for the complex dot product accumulator.
// Mode codes and the control group between the product and accumulate stages.
package cdpa_pkg;

    localparam logic [1:0] MODE_BILINEAR = 2'd0;
    localparam logic [1:0] MODE_CONJ     = 2'd1;
    localparam logic [1:0] MODE_NORM     = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } cdpa_ctl_t;

endpackage

FILE: hdl/cdpa_mult.sv
// Input register and product stage: four signed multipliers with mode select.
// Depends on cdpa_pkg.
module cdpa_mult #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int PROD_W = 2 * SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] a_re,
    input  logic signed [SAMPLE_WIDTH-1:0] a_im,
    input  logic signed [SAMPLE_WIDTH-1:0] b_re,
    input  logic signed [SAMPLE_WIDTH-1:0] b_im,
    input  logic                           last,
    input  logic [1:0]                     mode,
    input  logic                           take,
    output cdpa_pkg::cdpa_ctl_t            ctl,
    output logic signed [PROD_W-1:0]       r1,
    output logic signed [PROD_W-1:0]       r2,
    output logic signed [PROD_W-1:0]       i1,
    output logic signed [PROD_W-1:0]       i2
);
    import cdpa_pkg::*;

    logic                           v1_reg;
    logic                           last1_reg;
    logic signed [SAMPLE_WIDTH-1:0] ar_reg;
    logic signed [SAMPLE_WIDTH-1:0] ai_reg;
    logic signed [SAMPLE_WIDTH-1:0] br_reg;
    logic signed [SAMPLE_WIDTH-1:0] bi_reg;

    logic                           v2_reg;
    logic                           last2_reg;
    logic signed [PROD_W-1:0]       r1_reg;
    logic signed [PROD_W-1:0]       r2_reg;
    logic signed [PROD_W-1:0]       i1_reg;
    logic signed [PROD_W-1:0]       i2_reg;

    logic                           load2;
    logic signed [SAMPLE_WIDTH-1:0] x1;
    logic signed [SAMPLE_WIDTH-1:0] x2;
    logic signed [PROD_W-1:0]       p_r1;
    logic signed [PROD_W-1:0]       p_r2;
    logic signed [PROD_W-1:0]       p_i1;
    logic signed [PROD_W-1:0]       p_i2;
    logic signed [PROD_W-1:0]       r1_next;
    logic signed [PROD_W-1:0]       r2_next;
    logic signed [PROD_W-1:0]       i1_next;
    logic signed [PROD_W-1:0]       i2_next;

    assign load2    = !v2_reg || take;
    assign in_ready = !v1_reg || load2;

    // norm mode squares a, so the real multipliers take a in place of b
    assign x1 = (mode == MODE_NORM) ? ar_reg : br_reg;
    assign x2 = (mode == MODE_NORM) ? ai_reg : bi_reg;

    assign p_r1 = ar_reg * x1;
    assign p_r2 = ai_reg * x2;
    assign p_i1 = ar_reg * bi_reg;
    assign p_i2 = ai_reg * br_reg;

    always_comb
    begin
        r1_next = p_r1;
        r2_next = -p_r2;
        i1_next = p_i1;
        i2_next = p_i2;
        case (mode)
            MODE_CONJ:
            begin
                r2_next = p_r2;
                i2_next = -p_i2;
            end
            MODE_NORM:
            begin
                r2_next = p_r2;
                i1_next = '0;
                i2_next = '0;
            end
            default:
            begin
                r2_next = -p_r2;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v1_reg <= in_valid;
            if (load2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ar_reg    <= a_re;
            ai_reg    <= a_im;
            br_reg    <= b_re;
            bi_reg    <= b_im;
            last1_reg <= last;
        end
        if (v1_reg && load2)
        begin
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            i1_reg    <= i1_next;
            i2_reg    <= i2_next;
            last2_reg <= last1_reg;
        end
    end

    assign ctl.valid = v2_reg;
    assign ctl.last  = last2_reg;
    assign r1 = r1_reg;
    assign r2 = r2_reg;
    assign i1 = i1_reg;
    assign i2 = i2_reg;

endmodule

FILE: hdl/cdpa_acc.sv
// Saturating complex accumulator with sticky overflow and the result register.
// Depends on cdpa_pkg.
module cdpa_acc #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 48,
    localparam int PROD_W = 2 * SAMPLE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdpa_pkg::cdpa_ctl_t         ctl,
    input  logic signed [PROD_W-1:0]    r1,
    input  logic signed [PROD_W-1:0]    r2,
    input  logic signed [PROD_W-1:0]    i1,
    input  logic signed [PROD_W-1:0]    i2,
    output logic                        take,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [ACC_WIDTH-1:0] sum_re,
    output logic signed [ACC_WIDTH-1:0] sum_im,
    output logic                        overflow
);
    import cdpa_pkg::*;

    localparam int WIDE_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 2;
    localparam logic signed [WIDE_W-1:0] ACC_MAX =
        signed'(WIDE_W'({1'b0, {(ACC_WIDTH-1){1'b1}}}));
    localparam logic signed [WIDE_W-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [ACC_WIDTH-1:0] acc_re_reg;
    logic signed [ACC_WIDTH-1:0] acc_im_reg;
    logic                        sat_reg;
    logic                        out_valid_reg;
    logic signed [ACC_WIDTH-1:0] sum_re_reg;
    logic signed [ACC_WIDTH-1:0] sum_im_reg;
    logic                        overflow_reg;

    logic signed [WIDE_W-1:0]    wide_re;
    logic signed [WIDE_W-1:0]    wide_im;
    logic signed [ACC_WIDTH-1:0] acc_re_next;
    logic signed [ACC_WIDTH-1:0] acc_im_next;
    logic                        sat_next;
    logic                        out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign take     = ctl.valid && (!ctl.last || out_free);

    assign wide_re = WIDE_W'(acc_re_reg) + WIDE_W'(r1) + WIDE_W'(r2);
    assign wide_im = WIDE_W'(acc_im_reg) + WIDE_W'(i1) + WIDE_W'(i2);

    always_comb
    begin
        sat_next = sat_reg;
        if (wide_re > ACC_MAX)
        begin
            acc_re_next = ACC_MAX[ACC_WIDTH-1:0];
            sat_next    = 1'b1;
        end
        else if (wide_re < ACC_MIN)
        begin
            acc_re_next = ACC_MIN[ACC_WIDTH-1:0];
            sat_next    = 1'b1;
        end
        else
            acc_re_next = wide_re[ACC_WIDTH-1:0];

        if (wide_im > ACC_MAX)
        begin
            acc_im_next = ACC_MAX[ACC_WIDTH-1:0];
            sat_next    = 1'b1;
        end
        else if (wide_im < ACC_MIN)
        begin
            acc_im_next = ACC_MIN[ACC_WIDTH-1:0];
            sat_next    = 1'b1;
        end
        else
            acc_im_next = wide_im[ACC_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg    <= '0;
            acc_im_reg    <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && ctl.last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (take)
            begin
                if (ctl.last)
                begin
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                    sat_reg    <= 1'b0;
                end
                else
                begin
                    acc_re_reg <= acc_re_next;
                    acc_im_reg <= acc_im_next;
                    sat_reg    <= sat_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && ctl.last)
        begin
            sum_re_reg   <= acc_re_next;
            sum_im_reg   <= acc_im_next;
            overflow_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum_re    = sum_re_reg;
    assign sum_im    = sum_im_reg;
    assign overflow  = overflow_reg;

endmodule

FILE: hdl/complex_dot_product_accumulator_unit.sv
// Complex dot product accumulator, top level.
// Holds the mode register and joins cdpa_mult and cdpa_acc; uses cdpa_pkg.
//
// Usage:
//   s_* stream carries one element pair per item: a_re, a_im, b_re, b_im in
//   s_tdata, s_tlast marks the final element of a vector pair.
//   m_* stream carries one result per vector: sum_re and sum_im in m_tdata,
//   the sticky overflow flag in m_tuser.
//   cfg_valid/cfg_data write the mode (0 a*b, 1 conj(a)*b, 2 |a|^2); cfg_ready
//   is always high. Write it only while no vector is in flight.
// Flow:
//   One item per cycle, unless a last item waits for the result register.
//   A last item is captured in the input register, the four multipliers
//   then load the product register, and the accumulate-and-saturate step
//   loads the result register, which raises m_tvalid.
// Reset clears the accumulators, overflow flag, mode and all valid flags.
// When m_tready is low, items without tlast keep accumulating; a last item
// waits in the product stage until the result register frees, and the input
// side backs up behind it.
module complex_dot_product_accumulator_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 48,
    localparam int S_TDATA_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * ACC_WIDTH + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // a_re, a_im, b_re, b_im, zero pad
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // sum_re, sum_im, zero pad
    output logic                 m_tuser,  // overflow
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data
);
    import cdpa_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PROD_W = 2 * SAMPLE_WIDTH;

    logic [1:0]                  mode_reg;
    cdpa_ctl_t                   ctl;
    logic                        take;
    logic signed [PROD_W-1:0]    r1;
    logic signed [PROD_W-1:0]    r2;
    logic signed [PROD_W-1:0]    i1;
    logic signed [PROD_W-1:0]    i2;
    logic signed [ACC_WIDTH-1:0] sum_re;
    logic signed [ACC_WIDTH-1:0] sum_im;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_BILINEAR;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    cdpa_mult #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .a_re     (signed'(s_tdata[SW-1:0])),
        .a_im     (signed'(s_tdata[2*SW-1:SW])),
        .b_re     (signed'(s_tdata[3*SW-1:2*SW])),
        .b_im     (signed'(s_tdata[4*SW-1:3*SW])),
        .last     (s_tlast),
        .mode     (mode_reg),
        .take     (take),
        .ctl      (ctl),
        .r1       (r1),
        .r2       (r2),
        .i1       (i1),
        .i2       (i2)
    );

    cdpa_acc #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .r1        (r1),
        .r2        (r2),
        .i1        (i1),
        .i2        (i2),
        .take      (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sum_re    (sum_re),
        .sum_im    (sum_im),
        .overflow  (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({sum_im, sum_re});

endmodule

FILE: hdl/cdpa_checker.sv
// Port-level checker for the complex dot product accumulator, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cdpa_checker #(
    parameter int ACC_WIDTH = 48,
    localparam int M_TDATA_W = ((2 * ACC_WIDTH + 7) / 8) * 8
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);
    // last items accepted whose result has not yet been taken
    logic [1:0] pend_reg;
    logic       last_in;
    logic       res_out;

    assign last_in = s_tvalid && s_tready && s_tlast;
    assign res_out = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else if (last_in && !res_out)
            pend_reg <= pend_reg + 2'd1;
        else if (res_out && !last_in)
            pend_reg <= pend_reg - 2'd1;
    end

    `CDPA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !m_tvalid, "result valid in reset")

    `CDPA_ASSERT(a_out_hold, clk, rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled result changed")

    `CDPA_ASSERT(a_no_spurious, clk, rst_n, m_tvalid |-> pend_reg != 2'd0,
        "result without a last item")

    `CDPA_ASSERT(a_pend_bound, clk, rst_n, pend_reg != 2'd0 || !res_out,
        "result count exceeds last items")

    `CDPA_ASSERT(a_full_stall, clk, rst_n, pend_reg == 2'd3 && !m_tready |-> !s_tready,
        "input accepted with pipeline full of results")

endmodule

bind complex_dot_product_accumulator_unit cdpa_checker #(
    .ACC_WIDTH(ACC_WIDTH)
) u_cdpa_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for complex_dot_product_accumulator_unit.
// Drives element pairs on the input stream and checks each dot product against a local
// predictor. Depends on cdpa_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_top;
    import cdpa_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam longint ACC_MAX = 64'sd140737488355327;
    localparam longint ACC_MIN = -64'sd140737488355328;
    localparam logic signed [15:0] S_MAX = 16'sh7fff;
    localparam logic signed [15:0] S_MIN = 16'sh8000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASE_ITEMS = 500;
    localparam int FULL_SCALE_RUN = 40;

    // a_re in the low bits, b_im in the top bits
    typedef struct packed {
        logic signed [15:0] b_im;
        logic signed [15:0] b_re;
        logic signed [15:0] a_im;
        logic signed [15:0] a_re;
    } elem_t;

    typedef struct packed {
        logic               ovf;
        logic signed [47:0] im;
        logic signed [47:0] re;
    } dot_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;      // a_re, a_im, b_re, b_im
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;           // sum_re, sum_im
    logic        m_tuser;           // overflow
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;

    // predictor state
    logic signed [47:0] acc_re = '0;
    logic signed [47:0] acc_im = '0;
    bit                 sat_flag = 1'b0;
    logic [1:0]         mode_shadow = MODE_BILINEAR;
    dot_result_t        expected_sums[$];

    bit sender_gappy = 1'b1;
    bit sink_stalls = 1'b1;
    int stall_left = 0;
    int idle_cycles = 0;
    int elements_sent = 0;
    int results_checked = 0;
    int saturated_results = 0;
    int mode_writes = 0;
    int mismatches = 0;

    complex_dot_product_accumulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [1:0] mode_by_slot(input int slot);
        case (slot)
            0:       return MODE_BILINEAR;
            1:       return MODE_CONJ;
            2:       return MODE_NORM;
            default: return MODE_SPARE;
        endcase
    endfunction

    function automatic elem_t make_elem(input logic signed [15:0] ar, input logic signed [15:0] ai,
                                        input logic signed [15:0] br, input logic signed [15:0] bi);
        elem_t e;
        e.a_re = ar;
        e.a_im = ai;
        e.b_re = br;
        e.b_im = bi;
        return e;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        logic [15:0] raw;
        raw = 16'($urandom());
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 16'sd0;
            default: return raw;
        endcase
    endfunction

    function automatic elem_t random_elem();
        return make_elem(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endfunction

    function automatic logic signed [47:0] clamp48(input longint v);
        if (v > ACC_MAX)
            return 48'sh7fff_ffff_ffff;
        if (v < ACC_MIN)
            return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    // one element into the accumulators; a last element closes the vector
    function automatic void accumulate_element(input elem_t e, input bit last);
        longint ar, ai, br, bi, re_sum, im_sum;
        dot_result_t res;
        ar = e.a_re;
        ai = e.a_im;
        br = e.b_re;
        bi = e.b_im;
        case (mode_shadow)
            MODE_CONJ:
            begin
                re_sum = acc_re + ar * br + ai * bi;
                im_sum = acc_im + ar * bi - ai * br;
            end
            MODE_NORM:
            begin
                re_sum = acc_re + ar * ar + ai * ai;
                im_sum = acc_im;
            end
            default:
            begin
                re_sum = acc_re + ar * br - ai * bi;
                im_sum = acc_im + ar * bi + ai * br;
            end
        endcase
        if (re_sum > ACC_MAX || re_sum < ACC_MIN || im_sum > ACC_MAX || im_sum < ACC_MIN)
            sat_flag = 1'b1;
        acc_re = clamp48(re_sum);
        acc_im = clamp48(im_sum);
        if (last)
        begin
            res.re = acc_re;
            res.im = acc_im;
            res.ovf = sat_flag;
            expected_sums.push_back(res);
            acc_re = '0;
            acc_im = '0;
            sat_flag = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_element(input elem_t e, input bit last);
        int gap;
        gap = sender_gappy ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= e;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        accumulate_element(e, last);
        elements_sent++;
    endtask

    task automatic write_mode(input logic [1:0] m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_shadow = m;
        mode_writes++;
    endtask

    // hold the sender until all sums are out and the pipeline has drained
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic test_modes();
        // reset mode is bilinear
        push_element(make_elem(16'sd16384, -16'sd8192, 16'sd3, 16'sd4), 1'b1);
        for (int k = 0; k < 4; k++)
        begin
            settle(DRAIN_CYCLES);
            write_mode(mode_by_slot(k));
            push_element(make_elem(S_MIN, S_MIN, S_MIN, S_MIN), 1'b0);
            push_element(make_elem(S_MAX, S_MAX, S_MAX, S_MAX), 1'b0);
            push_element(make_elem(S_MIN, S_MAX, S_MAX, S_MIN), 1'b0);
            push_element(make_elem(16'sd0, -16'sd1, 16'sd1, 16'sd0), 1'b1);
        end
        // switch to norm part way through a vector, imag sum must be kept
        settle(DRAIN_CYCLES);
        write_mode(MODE_BILINEAR);
        push_element(make_elem(S_MAX, S_MIN, S_MIN, S_MAX), 1'b0);
        push_element(make_elem(16'sd1234, -16'sd77, S_MIN, 16'sd900), 1'b0);
        settle(DRAIN_CYCLES);
        write_mode(MODE_NORM);
        push_element(make_elem(S_MIN, S_MAX, S_MIN, S_MAX), 1'b0);
        push_element(make_elem(-16'sd5, 16'sd7, 16'sd0, 16'sd0), 1'b1);
    endtask

    task automatic test_full_scale();
        elem_t up, down;
        up = make_elem(S_MIN, 16'sd0, S_MIN, S_MIN);
        down = make_elem(S_MIN, 16'sd0, S_MAX, S_MAX);
        settle(DRAIN_CYCLES);
        write_mode(MODE_BILINEAR);
        sender_gappy = 1'b0;
        // about 2^30 per item on both parts, back to back, one sign per run
        repeat (FULL_SCALE_RUN) push_element(up, 1'b0);
        repeat (6) push_element(random_elem(), 1'b0);
        push_element(up, 1'b1);
        repeat (FULL_SCALE_RUN) push_element(down, 1'b0);
        repeat (6) push_element(random_elem(), 1'b0);
        push_element(down, 1'b1);
        push_element(random_elem(), 1'b1);
        sender_gappy = 1'b1;
    endtask

    task automatic test_random();
        int left, run, r;
        for (int p = 0; p < 4; p++)
        begin
            settle(DRAIN_CYCLES);
            write_mode(mode_by_slot((p + 1) % 4));
            sender_gappy = (p == 0 || p == 2);
            sink_stalls = (p <= 1);
            left = RANDOM_PHASE_ITEMS;
            while (left > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    run = $urandom_range(1, 8);
                else if (r < 95)
                    run = $urandom_range(9, 32);
                else
                    run = $urandom_range(33, 120);
                if (run > left)
                    run = left;
                for (int k = 0; k < run; k++)
                    push_element(random_elem(), k == run - 1);
                left -= run;
            end
        end
        sender_gappy = 1'b1;
        sink_stalls = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : result_check
        dot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t unexpected item: expected none, actual re %0d im %0d ovf %0b",
                         $time, $signed(m_tdata[47:0]), $signed(m_tdata[95:48]), m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_sums.pop_front();
                check_field("sum_re", want.re, $signed(m_tdata[47:0]));
                check_field("sum_im", want.im, $signed(m_tdata[95:48]));
                check_field("overflow", want.ovf, m_tuser);
                results_checked++;
                if (want.ovf)
                    saturated_results++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: nothing moved for %0d cycles, %0d sums outstanding",
                         $time, WATCHDOG_LIMIT, expected_sums.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_modes();
        test_full_scale();
        test_random();
        settle(TAIL_CYCLES);
        $display("%0d element pairs in, %0d dot products checked (%0d saturated), %0d mode writes",
                 elements_sent, results_checked, saturated_results, mode_writes);
        $display("all four mode codes, full-scale samples, same-sign runs and stalls on each side");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/cdpa_pkg.sv
hdl/cdpa_mult.sv
hdl/cdpa_acc.sv
hdl/complex_dot_product_accumulator_unit.sv
hdl/cdpa_checker.sv
tb/tb_top.sv
